// ===== rtl/core/keyed_fifo_with_cancel_unit_assert.svh =====
// Assertion macros for the keyed record queue.
`ifndef KEYED_FIFO_WITH_CANCEL_UNIT_ASSERT_SVH
`define KEYED_FIFO_WITH_CANCEL_UNIT_ASSERT_SVH

// Clocked assertion, off during reset.
`define KFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define KFC_NEVER(lbl, cond, msg) \
  `KFC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/kfc_pkg.sv =====
// Types and codes shared by the keyed record queue.
package kfc_pkg;

  localparam int unsigned DefDepth = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_PROC   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CO_NOP,
    CO_SEARCH,
    CO_WRITE,
    CO_APPEND,
    CO_REMOVE,
    CO_POP
  } cell_op_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] customer;
    logic [31:0] cost;
  } rec_t;

  typedef struct packed {
    cell_op_e op;
    rec_t     rec;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
  } chain_stat_t;

endpackage

// ===== rtl/core/keyed_fifo_with_cancel_unit.sv =====
// Keyed record queue: insert, update, cancel by id, pop from head.
// Insert, update, cancel, and process with count 0: busy in the apply state, result strobe in the
// cycle after it; a new word is taken only while not busy. Process of n records: busy in the pop state,
// one result per busy cycle, each shown in the cycle after, and a last EMPTY result when fewer than
// n records are held; the single-shift chain moves one record per cycle, which sets the pop rate.
// Key search is one compare per cell, registered, then oldest-match select in the next cycle.
// Reset clears all valid bits and the controller; results cannot be stalled by the receiver.
module keyed_fifo_with_cancel_unit #(
  parameter int unsigned DEPTH = kfc_pkg::DefDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] order_id_i,
  input  logic signed [31:0] customer_no_i,
  input  logic [31:0]        cost_bits_i,
  input  logic [7:0]         item_count_i,
  output logic               res_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_id_o,
  output logic signed [31:0] out_customer_o,
  output logic [31:0]        out_cost_o,
  output logic               has_record_o,
  output logic               last_o
);
  import kfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_POP
  } state_e;

  state_e      state_q, state_d;
  mode_e       mode_q, mode_d;
  rec_t        cmd_q, cmd_d;
  logic [7:0]  count_q, count_d;
  logic        rv_q, rv_d;
  status_e     st_q, st_d;
  rec_t        orec_q, orec_d;
  logic        has_q, has_d;
  logic        last_q, last_d;

  cell_ctrl_t  ctrl;
  chain_stat_t stat;
  rec_t        head;

  kfc_chain #(.DEPTH(DEPTH)) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .stat_o(stat),
    .head_o(head)
  );

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    cmd_d    = cmd_q;
    count_d  = count_q;
    rv_d     = 1'b0;
    st_d     = STAT_OK;
    orec_d   = '0;
    has_d    = 1'b0;
    last_d   = 1'b0;
    ctrl.op  = CO_NOP;
    ctrl.rec = cmd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_d           = mode_e'(mode_i);
          cmd_d.key        = order_id_i;
          cmd_d.customer   = customer_no_i;
          cmd_d.cost       = cost_bits_i;
          count_d          = item_count_i;
          ctrl.op          = CO_SEARCH;
          ctrl.rec.key     = order_id_i;
          if (mode_e'(mode_i) == MODE_PROC && item_count_i != 8'd0) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        rv_d    = 1'b1;
        last_d  = 1'b1;
        state_d = ST_IDLE;
        unique case (mode_q)
          MODE_INSERT: begin
            if (stat.hit) begin
              ctrl.op = CO_WRITE;
            end else if (stat.full) begin
              st_d = STAT_FULL;
            end else begin
              ctrl.op = CO_APPEND;
            end
          end
          MODE_UPDATE: begin
            if (stat.hit) begin
              ctrl.op = CO_WRITE;
            end else begin
              st_d = STAT_NOTFOUND;
            end
          end
          MODE_CANCEL: begin
            if (stat.hit) begin
              ctrl.op = CO_REMOVE;
            end else begin
              st_d = STAT_NOTFOUND;
            end
          end
          default: begin
          end
        endcase
      end
      ST_POP: begin
        rv_d = 1'b1;
        if (stat.empty) begin
          st_d    = STAT_EMPTY;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ctrl.op = CO_POP;
          orec_d  = head;
          has_d   = 1'b1;
          count_d = count_q - 8'd1;
          if (count_q == 8'd1) begin
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_INSERT;
      cmd_q   <= '0;
      count_q <= '0;
      rv_q    <= 1'b0;
      st_q    <= STAT_OK;
      orec_q  <= '0;
      has_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cmd_q   <= cmd_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      st_q    <= st_d;
      orec_q  <= orec_d;
      has_q   <= has_d;
      last_q  <= last_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign res_valid_o    = rv_q;
  assign status_o       = st_q;
  assign out_id_o       = orec_q.key;
  assign out_customer_o = orec_q.customer;
  assign out_cost_o     = orec_q.cost;
  assign has_record_o   = has_q;
  assign last_o         = last_q;

`include "keyed_fifo_with_cancel_unit_assert.svh"

  `KFC_ASSERT(a_res_after_busy, res_valid_o |-> $past(busy), "result without prior work")
  `KFC_NEVER(a_rec_status, has_record_o && (status_o != STAT_OK), "record with bad status")
  `KFC_ASSERT(a_one_done, start && !busy && mode_i != MODE_PROC |-> ##2 last_o, "no single result")
  `KFC_NEVER(a_last_idle, res_valid_o && (last_o == busy), "last flag out of step with busy")

endmodule

// ===== rtl/core/kfc_cell.sv =====
// One storage cell of the record chain.
module kfc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kfc_pkg::cell_ctrl_t ctrl_i,
  input  logic               first_i,
  input  logic               ge_i,
  input  logic               left_valid_i,
  input  logic               right_valid_i,
  input  kfc_pkg::rec_t      right_rec_i,
  output logic               valid_o,
  output kfc_pkg::rec_t      rec_o,
  output logic               match_o
);
  import kfc_pkg::*;

  logic valid_q, valid_d;
  logic match_q, match_d;
  rec_t rec_q, rec_d;

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    rec_d   = rec_q;
    case (ctrl_i.op)
      CO_SEARCH: begin
        match_d = valid_q && (rec_q.key == ctrl_i.rec.key);
      end
      CO_WRITE: begin
        if (first_i) begin
          rec_d.customer = ctrl_i.rec.customer;
          rec_d.cost     = ctrl_i.rec.cost;
        end
      end
      CO_APPEND: begin
        if (!valid_q && left_valid_i) begin
          valid_d = 1'b1;
          rec_d   = ctrl_i.rec;
        end
      end
      CO_REMOVE: begin
        if (ge_i) begin
          valid_d = right_valid_i;
          rec_d   = right_rec_i;
        end
      end
      CO_POP: begin
        valid_d = right_valid_i;
        rec_d   = right_rec_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/kfc_chain.sv =====
// Row of record cells with oldest-match selection.
module kfc_chain #(
  parameter int unsigned DEPTH = kfc_pkg::DefDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfc_pkg::cell_ctrl_t ctrl_i,
  output kfc_pkg::chain_stat_t stat_o,
  output kfc_pkg::rec_t       head_o
);
  import kfc_pkg::*;

  logic [DEPTH:0]   valid_ext;
  rec_t             rec_ext [DEPTH+1];
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] ge;

  assign valid_ext[DEPTH] = 1'b0;
  assign rec_ext[DEPTH]   = '0;

  assign first = match & (~match + DEPTH'(1));
  assign ge    = ~(first - DEPTH'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic left_valid;
    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = valid_ext[i-1];
    end
    kfc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .first_i      (first[i]),
      .ge_i         (ge[i]),
      .left_valid_i (left_valid),
      .right_valid_i(valid_ext[i+1]),
      .right_rec_i  (rec_ext[i+1]),
      .valid_o      (valid_ext[i]),
      .rec_o        (rec_ext[i]),
      .match_o      (match[i])
    );
  end

  assign stat_o.hit   = |match;
  assign stat_o.full  = valid_ext[DEPTH-1];
  assign stat_o.empty = !valid_ext[0];
  assign head_o       = rec_ext[0];

endmodule

// ===== tb/sv/keyed_fifo_order_checker.sv =====
// Checker for the keyed record queue: predicts each word's results and compares them.
module keyed_fifo_order_checker #(
  parameter int unsigned DEPTH = kfc_pkg::DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] order_id_i,
  input  logic [31:0] customer_no_i,
  input  logic [31:0] cost_bits_i,
  input  logic [7:0]  item_count_i,
  input  logic        res_valid_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] out_id_i,
  input  logic [31:0] out_customer_i,
  input  logic [31:0] out_cost_i,
  input  logic        has_record_i,
  input  logic        last_i,
  output int          fail_count,
  output int          open_results
);
  import kfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic [31:0] id;
    logic [31:0] customer;
    logic [31:0] cost;
    logic        has_record;
    logic        last;
  } order_result_t;

  order_result_t queued_results[$];
  logic [31:0]   held_id[DEPTH];
  logic [31:0]   held_cust[DEPTH];
  logic [31:0]   held_cost[DEPTH];
  int unsigned   fill = 0;

  initial begin
    fail_count   = 0;
    open_results = 0;
  end

  function automatic void queue_result(status_e st, logic [31:0] id, logic [31:0] cu,
                                       logic [31:0] co, logic rec, logic fin);
    queued_results.push_back('{st, id, cu, co, rec, fin});
  endfunction

  function automatic void drop_record(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fill; i++) begin
      held_id[i]   = held_id[i + 1];
      held_cust[i] = held_cust[i + 1];
      held_cost[i] = held_cost[i + 1];
    end
    fill--;
  endfunction

  function automatic void predict_order(mode_e m, logic [31:0] key, logic [31:0] cu,
                                        logic [31:0] co, logic [7:0] cnt);
    int          hit;
    int unsigned left;
    hit  = -1;
    left = cnt;
    if (m == MODE_PROC) begin
      if (left == 0) queue_result(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
      while (left > 0) begin
        if (fill == 0) begin
          queue_result(STAT_EMPTY, '0, '0, '0, 1'b0, 1'b1);
          left = 0;
        end else begin
          queue_result(STAT_OK, held_id[0], held_cust[0], held_cost[0], 1'b1, left == 1);
          drop_record(0);
          left--;
        end
      end
      return;
    end
    for (int i = int'(fill) - 1; i >= 0; i--) begin
      if (held_id[i] == key) hit = i;
    end
    case (m)
      MODE_INSERT: begin
        if (hit >= 0) begin
          held_cust[hit] = cu;
          held_cost[hit] = co;
          queue_result(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
        end else if (fill >= DEPTH) begin
          queue_result(STAT_FULL, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          held_id[fill]   = key;
          held_cust[fill] = cu;
          held_cost[fill] = co;
          fill++;
          queue_result(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      MODE_UPDATE: begin
        if (hit >= 0) begin
          held_cust[hit] = cu;
          held_cost[hit] = co;
          queue_result(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          queue_result(STAT_NOTFOUND, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        if (hit >= 0) begin
          drop_record(unsigned'(hit));
          queue_result(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          queue_result(STAT_NOTFOUND, '0, '0, '0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    order_result_t want;
    if (rst_ni) begin
      if (res_valid_i !== 1'b0) begin
        if (queued_results.size() == 0) begin
          $display("%0t: result mismatch: expected none, actual status %0d id %h last %b",
                   $time, status_i, out_id_i, last_i);
          fail_count++;
        end else begin
          want = queued_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("out_id", want.id, out_id_i);
          check_field("out_customer", want.customer, out_customer_i);
          check_field("out_cost", want.cost, out_cost_i);
          check_field("has_record", 32'(want.has_record), 32'(has_record_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (start && !busy) begin
        predict_order(mode_e'(mode_i), order_id_i, customer_no_i, cost_bits_i, item_count_i);
      end
    end
    open_results = queued_results.size();
  end

endmodule

// ===== tb/sv/keyed_fifo_with_cancel_unit_test.sv =====
// Top of the keyed record queue testbench: clock, reset, stimulus and verdict.
module keyed_fifo_with_cancel_unit_test;
  import kfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = DefDepth;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          POOL_SIZE  = 24;
  localparam int          RAND_WORDS = 210;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         mode_d;
  logic signed [31:0] id_d;
  logic signed [31:0] cust_d;
  logic [31:0]        cost_d;
  logic [7:0]         count_d;
  logic               res_valid;
  logic [1:0]         status;
  logic signed [31:0] out_id;
  logic signed [31:0] out_customer;
  logic [31:0]        out_cost;
  logic               has_record;
  logic               last;

  int          fail_count;
  int          open_results;
  int          cycles = 0;
  int          burst_left = 0;
  logic        fill_phase = 1'b0;
  logic [31:0] key_pool[POOL_SIZE];

  always #10ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  keyed_fifo_with_cancel_unit #(.DEPTH(DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_d),
    .order_id_i     (id_d),
    .customer_no_i  (cust_d),
    .cost_bits_i    (cost_d),
    .item_count_i   (count_d),
    .res_valid_o    (res_valid),
    .status_o       (status),
    .out_id_o       (out_id),
    .out_customer_o (out_customer),
    .out_cost_o     (out_cost),
    .has_record_o   (has_record),
    .last_o         (last)
  );

  keyed_fifo_order_checker #(.DEPTH(DEPTH)) order_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_d),
    .order_id_i     (id_d),
    .customer_no_i  (cust_d),
    .cost_bits_i    (cost_d),
    .item_count_i   (count_d),
    .res_valid_i    (res_valid),
    .status_i       (status),
    .out_id_i       (out_id),
    .out_customer_i (out_customer),
    .out_cost_i     (out_cost),
    .has_record_i   (has_record),
    .last_i         (last),
    .fail_count     (fail_count),
    .open_results   (open_results)
  );

  task automatic send_word(mode_e m, logic [31:0] id, logic [31:0] cu, logic [31:0] co,
                           logic [7:0] cnt);
    mode_d  <= m;
    id_d    <= id;
    cust_d  <= cu;
    cost_d  <= co;
    count_d <= cnt;
    start   <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold until every queued result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    wait (open_results == 0 && !busy);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_count(logic deep);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd255;
    if (r < 16) return 8'($urandom_range(0, 255));
    return deep ? 8'($urandom_range(0, 5)) : 8'($urandom_range(1, 2));
  endfunction

  task automatic send_random();
    int    r;
    mode_e m;
    r = $urandom_range(0, 99);
    if (fill_phase) begin
      m = (r < 60) ? MODE_INSERT : (r < 75) ? MODE_UPDATE : (r < 85) ? MODE_CANCEL : MODE_PROC;
    end else begin
      m = (r < 30) ? MODE_INSERT : (r < 45) ? MODE_UPDATE : (r < 70) ? MODE_CANCEL : MODE_PROC;
    end
    send_word(m, pick_key(), $urandom, $urandom, pick_count(!fill_phase));
  endtask

  initial begin
    logic [31:0] cu;
    logic [31:0] co;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    mode_d  <= MODE_INSERT;
    id_d    <= '0;
    cust_d  <= '0;
    cost_d  <= '0;
    count_d <= '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = ($urandom & 32'hffff_ff00) | i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(MODE_PROC, '0, '0, '0, 8'd0);
    send_word(MODE_PROC, '0, '0, '0, 8'd1);
    send_word(MODE_UPDATE, key_pool[5], 32'h1234_5678, 32'h9abc_def0, 8'd0);
    send_word(MODE_CANCEL, key_pool[5], '0, '0, 8'd0);
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: begin cu = 32'h8000_0000; co = 32'h0000_0000; end
        1: begin cu = 32'h7fff_ffff; co = 32'hffff_ffff; end
        2: begin cu = 32'hffff_ffff; co = 32'h0000_0000; end
        default: begin cu = $urandom; co = $urandom; end
      endcase
      send_word(MODE_INSERT, key_pool[i], cu, co, 8'($urandom));
      pace();
    end
    send_word(MODE_INSERT, key_pool[DEPTH], 32'h5555_aaaa, 32'haaaa_5555, 8'd0);
    send_word(MODE_INSERT, key_pool[3], 32'h0000_0001, 32'h8000_0000, 8'd0);
    send_word(MODE_UPDATE, key_pool[1], 32'hffff_fffe, 32'h7fff_ffff, 8'd0);
    send_word(MODE_CANCEL, key_pool[7], '0, '0, 8'd0);
    send_word(MODE_PROC, '0, '0, '0, 8'd255);
    drain();

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 35 == 0) fill_phase = ~fill_phase;
      if (n == 100) drain();
      send_random();
      pace();
    end
    drain();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && open_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
